>>> src/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg: shared constants and types of the triangle shape function block
// Field widths, stream packing and the divider tag carried along the cells.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int NUM_FIELDS      = 8;
  localparam int S_TDATA_W       = FIELD_W * NUM_FIELDS;

  localparam int TOL_W   = 33;
  localparam int AREA_W  = 34;
  localparam int CENT_W  = 16;
  localparam int SHAPE_W = 21;
  localparam int GRAD_W  = 24;

  // quotient bits produced by the cell row and the fraction bits of a shape value
  localparam int QUOT_BITS  = 24;
  localparam int FRAC_BITS  = 16;
  localparam int GRAD_SHIFT = QUOT_BITS - FRAC_BITS;

  localparam int FRONT_LAT = 4;
  localparam int DIV_LAT   = QUOT_BITS + 2;

  // result packing, lowest field first
  localparam int OFS_AREA  = 0;
  localparam int OFS_CX    = OFS_AREA + AREA_W;
  localparam int OFS_CY    = OFS_CX + CENT_W;
  localparam int OFS_S0    = OFS_CY + CENT_W;
  localparam int OFS_S1    = OFS_S0 + SHAPE_W;
  localparam int OFS_S2    = OFS_S1 + SHAPE_W;
  localparam int OFS_G0X   = OFS_S2 + SHAPE_W;
  localparam int OFS_G0Y   = OFS_G0X + GRAD_W;
  localparam int OFS_G1X   = OFS_G0Y + GRAD_W;
  localparam int OFS_G1Y   = OFS_G1X + GRAD_W;
  localparam int OFS_G2    = OFS_G1Y + GRAD_W;
  localparam int USED_W    = OFS_G2 + 2 * GRAD_W;
  localparam int M_TDATA_W = ((USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic neg;
    logic ovf;
  } div_tag_t;

endpackage

>>> src/lts_front.sv
// ----------------------------------------------------------------------------
// lts_front: area, sub-areas, gradient numerators and centroid
// Four register stages: differences, products, combine, magnitude and scale.
// ----------------------------------------------------------------------------
module lts_front import lts_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [S_TDATA_W-1:0]                          s_tdata,
  input  logic [TOL_W-1:0]                              tol,
  output logic signed [2*COORD_WIDTH+2:0]               area,
  output logic                                          degen,
  output logic [CENT_W-1:0]                             cent_x,
  output logic [CENT_W-1:0]                             cent_y,
  output logic signed [2*COORD_WIDTH+2:0]               e_num [3],
  output logic signed [COORD_WIDTH+GRAD_SHIFT:0]        gx_num [3],
  output logic signed [COORD_WIDTH+GRAD_SHIFT:0]        gy_num [3]
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int SW = CW + 2;
  localparam int PW = 2 * CW + 2;
  localparam int EW = 2 * CW + 3;
  localparam int TW = (EW > TOL_W) ? EW : TOL_W;
  localparam int K  = CW + 3;
  localparam int MW = K + DW;
  localparam logic [K-1:0] RECIP3 = K'(((64'd1 << K) + 64'd2) / 64'd3);

  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [CW-1:0] qx, qy;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      vx[j] = CW'(s_tdata[2*j*FIELD_W +: FIELD_W]);
      vy[j] = CW'(s_tdata[(2*j+1)*FIELD_W +: FIELD_W]);
    end
    qx = CW'(s_tdata[6*FIELD_W +: FIELD_W]);
    qy = CW'(s_tdata[7*FIELD_W +: FIELD_W]);
  end

  // stage A
  logic signed [DW-1:0] dx1, dy2, dx2, dy1;
  logic signed [DW-1:0] ux [3];
  logic signed [DW-1:0] uy [3];
  logic signed [DW-1:0] gdy [3];
  logic signed [DW-1:0] gdx [3];
  logic signed [SW-1:0] sx, sy;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= DW'(vx[1]) - DW'(vx[0]);
      dy2 <= DW'(vy[2]) - DW'(vy[0]);
      dx2 <= DW'(vx[2]) - DW'(vx[0]);
      dy1 <= DW'(vy[1]) - DW'(vy[0]);
      for (int j = 0; j < 3; j++) begin
        ux[j]  <= DW'(vx[j]) - DW'(qx);
        uy[j]  <= DW'(vy[j]) - DW'(qy);
        gdy[j] <= DW'(vy[(j+1)%3]) - DW'(vy[(j+2)%3]);
        gdx[j] <= DW'(vx[(j+2)%3]) - DW'(vx[(j+1)%3]);
      end
      sx <= SW'(vx[0]) + SW'(vx[1]) + SW'(vx[2]);
      sy <= SW'(vy[0]) + SW'(vy[1]) + SW'(vy[2]);
    end
  end

  // stage B
  logic signed [PW-1:0] p1, p2;
  logic signed [PW-1:0] pe1 [3];
  logic signed [PW-1:0] pe2 [3];
  logic signed [DW+GRAD_SHIFT-1:0] gnx_b [3];
  logic signed [DW+GRAD_SHIFT-1:0] gny_b [3];
  logic [DW-1:0] nx, ny;
  logic          sgx_b, sgy_b;

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= PW'(dx1) * PW'(dy2);
      p2 <= PW'(dx2) * PW'(dy1);
      for (int j = 0; j < 3; j++) begin
        pe1[j]   <= PW'(ux[(j+1)%3]) * PW'(uy[(j+2)%3]);
        pe2[j]   <= PW'(ux[(j+2)%3]) * PW'(uy[(j+1)%3]);
        gnx_b[j] <= $signed({gdy[j], {GRAD_SHIFT{1'b0}}});
        gny_b[j] <= $signed({gdx[j], {GRAD_SHIFT{1'b0}}});
      end
      nx    <= DW'(sx[SW-1] ? -sx : sx);
      ny    <= DW'(sy[SW-1] ? -sy : sy);
      sgx_b <= sx[SW-1];
      sgy_b <= sy[SW-1];
    end
  end

  // stage C
  logic signed [EW-1:0] d_c;
  logic signed [EW-1:0] e_c [3];
  logic signed [DW+GRAD_SHIFT-1:0] gx_c [3];
  logic signed [DW+GRAD_SHIFT-1:0] gy_c [3];
  logic [MW-1:0] mx, my;
  logic          sgx_c, sgy_c;

  always_ff @(posedge clk) begin
    if (en) begin
      d_c <= EW'(p1) - EW'(p2);
      for (int j = 0; j < 3; j++) begin
        e_c[j]  <= EW'(pe1[j]) - EW'(pe2[j]);
        gx_c[j] <= gnx_b[j];
        gy_c[j] <= gny_b[j];
      end
      mx    <= MW'(nx) * MW'(RECIP3);
      my    <= MW'(ny) * MW'(RECIP3);
      sgx_c <= sgx_b;
      sgy_c <= sgy_b;
    end
  end

  // stage D: the reciprocal of three is exact for these magnitudes
  logic [EW-1:0]        dmag;
  logic signed [SW-1:0] cxq, cyq;

  always_comb begin
    dmag = d_c[EW-1] ? EW'(-d_c) : EW'(d_c);
    cxq  = $signed({1'b0, mx[MW-1:K]});
    cyq  = $signed({1'b0, my[MW-1:K]});
    if (sgx_c) cxq = -cxq;
    if (sgy_c) cyq = -cyq;
  end

  // numerators leave together with the area they are divided by
  always_ff @(posedge clk) begin
    if (en) begin
      area   <= d_c;
      degen  <= TW'(dmag) <= TW'(tol);
      cent_x <= CENT_W'(cxq);
      cent_y <= CENT_W'(cyq);
      for (int j = 0; j < 3; j++) begin
        e_num[j]  <= e_c[j];
        gx_num[j] <= gx_c[j];
        gy_num[j] <= gy_c[j];
      end
    end
  end

endmodule

>>> src/lts_div_cell.sv
// ----------------------------------------------------------------------------
// lts_div_cell: one restoring division step
// Shift in one dividend bit, subtract the divisor when it fits, pass right.
// ----------------------------------------------------------------------------
module lts_div_cell import lts_pkg::*; #(
  parameter int DENW = 35
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DENW-1:0]      r_in,
  input  logic [QUOT_BITS-1:0] low_in,
  input  logic [QUOT_BITS-1:0] q_in,
  input  logic [DENW-1:0]      ud_in,
  input  div_tag_t             tag_in,
  output logic [DENW-1:0]      r_out,
  output logic [QUOT_BITS-1:0] low_out,
  output logic [QUOT_BITS-1:0] q_out,
  output logic [DENW-1:0]      ud_out,
  output div_tag_t             tag_out
);

  logic [DENW:0] rs, diff;
  logic          fits;

  always_comb begin
    rs   = {r_in, low_in[QUOT_BITS-1]};
    diff = rs - {1'b0, ud_in};
    fits = rs >= {1'b0, ud_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out   <= fits ? diff[DENW-1:0] : rs[DENW-1:0];
      low_out <= {low_in[QUOT_BITS-2:0], 1'b0};
      q_out   <= {q_in[QUOT_BITS-2:0], fits};
      ud_out  <= ud_in;
      tag_out <= tag_in;
    end
  end

endmodule

>>> src/lts_divider.sv
// ----------------------------------------------------------------------------
// lts_divider: saturating fixed point quotient trunc(num * 2^16 / den)
// Sign and range check, a row of division cells, then clamp to OUTW bits.
// ----------------------------------------------------------------------------
module lts_divider import lts_pkg::*; #(
  parameter int NUMW = 35,
  parameter int DENW = 35,
  parameter int OUTW = 24
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [NUMW-1:0] num,
  input  logic signed [DENW-1:0] den,
  output logic [OUTW-1:0]        quot
);

  localparam int CMPW = (NUMW > DENW + GRAD_SHIFT) ? NUMW : DENW + GRAD_SHIFT;
  localparam logic [QUOT_BITS-1:0] MAXV = QUOT_BITS'((64'd1 << (OUTW - 1)) - 64'd1);
  localparam logic [QUOT_BITS-1:0] LIM  = QUOT_BITS'(64'd1 << (OUTW - 1));

  logic [NUMW-1:0] un;
  logic [DENW-1:0] ud;

  always_comb begin
    un = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    ud = den[DENW-1] ? DENW'(-den) : DENW'(den);
  end

  logic [DENW-1:0]      r   [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] low [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q   [QUOT_BITS+1];
  logic [DENW-1:0]      udc [QUOT_BITS+1];
  div_tag_t             tag [QUOT_BITS+1];

  // quotient of 2^24 or more saturates either way
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]       <= DENW'(un >> GRAD_SHIFT);
      low[0]     <= {un[GRAD_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      q[0]       <= '0;
      udc[0]     <= ud;
      tag[0].neg <= num[NUMW-1] ^ den[DENW-1];
      tag[0].ovf <= CMPW'(un) >= CMPW'({ud, {GRAD_SHIFT{1'b0}}});
    end
  end

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
    lts_div_cell #(.DENW(DENW)) u_cell (
      .clk     (clk),
      .en      (en),
      .r_in    (r[i]),
      .low_in  (low[i]),
      .q_in    (q[i]),
      .ud_in   (udc[i]),
      .tag_in  (tag[i]),
      .r_out   (r[i+1]),
      .low_out (low[i+1]),
      .q_out   (q[i+1]),
      .ud_out  (udc[i+1]),
      .tag_out (tag[i+1])
    );
  end

  logic [OUTW-1:0] quot_next;
  logic [QUOT_BITS-1:0] qf;

  always_comb begin
    qf = q[QUOT_BITS];
    if (tag[QUOT_BITS].neg) begin
      if (tag[QUOT_BITS].ovf || qf > LIM) quot_next = OUTW'(~MAXV);
      else quot_next = OUTW'(~qf + 1'b1);
    end else begin
      if (tag[QUOT_BITS].ovf || qf > MAXV) quot_next = OUTW'(MAXV);
      else quot_next = OUTW'(qf);
    end
  end

  always_ff @(posedge clk) begin
    if (en) quot <= quot_next;
  end

endmodule

>>> src/linear_triangle_shape_functions.sv
// ----------------------------------------------------------------------------
// linear_triangle_shape_functions: barycentric shape values and gradients
// Twice-area, degeneracy, centroid, shape values and nodal gradients of a
// linear triangle for one query point per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one triangle plus query point per transaction (8 x Q8.8).
//   m_* returns one result per input transaction, in order; m_tuser is the
//   degenerate flag. A degenerate triangle returns zero shape values and
//   zero gradients.
//   cfg_we/cfg_wdata load the degeneracy tolerance (unsigned Q17.16 twice-area);
//   write it only while no transaction is in flight.
// Timing:
//   One transaction per cycle while the skid entry is empty. From input
//   acceptance to m_tvalid a transaction passes four arithmetic stages,
//   the sign/range stage, one division cell per quotient bit, the clamp
//   stage and the output register. The cell rows of the nine dividers set
//   the depth.
// Reset:
//   rst clears all valid flags and the tolerance; no result is pending.
// Backpressure:
//   The output register plus a one-entry skid buffer hold results while
//   m_tready is low; s_tready drops only once the skid entry is taken,
//   freezing the whole pipeline until the receiver drains it.
// ----------------------------------------------------------------------------
module linear_triangle_shape_functions import lts_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
  // query_x, query_y (16 bits each)
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // twice_area, centroid_x, centroid_y, shape0, shape1, shape2, grad0_x,
  // grad0_y, grad1_x, grad1_y, grad2_packed, zero fill
  output logic [M_TDATA_W-1:0] m_tdata,
  // degenerate
  output logic                 m_tuser,
  input  logic                 cfg_we,
  input  logic [TOL_W-1:0]     cfg_wdata
);

  localparam int CW  = COORD_WIDTH;
  localparam int EW  = 2 * CW + 3;
  localparam int GW  = CW + 1 + GRAD_SHIFT;
  localparam int LAT = FRONT_LAT + DIV_LAT;

  logic [TOL_W-1:0] tol;
  logic [LAT-1:0]   vld;
  logic             en;
  logic             skid_valid;

  // hold the whole pipeline while the skid entry is occupied
  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) tol <= '0;
    else if (cfg_we) tol <= cfg_wdata;
  end

  logic signed [EW-1:0] area_f;
  logic                 degen_f;
  logic [CENT_W-1:0]    cx_f, cy_f;
  logic signed [EW-1:0] e_num [3];
  logic signed [GW-1:0] gx_num [3];
  logic signed [GW-1:0] gy_num [3];

  lts_front #(.COORD_WIDTH(CW)) u_front (
    .clk     (clk),
    .en      (en),
    .s_tdata (s_tdata),
    .tol     (tol),
    .area    (area_f),
    .degen   (degen_f),
    .cent_x  (cx_f),
    .cent_y  (cy_f),
    .e_num   (e_num),
    .gx_num  (gx_num),
    .gy_num  (gy_num)
  );

  logic [SHAPE_W-1:0] shape [3];
  logic [GRAD_W-1:0]  gx [3];
  logic [GRAD_W-1:0]  gy [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    lts_divider #(.NUMW(EW), .DENW(EW), .OUTW(SHAPE_W)) u_shape (
      .clk (clk), .en (en), .num (e_num[k]), .den (area_f), .quot (shape[k])
    );
    lts_divider #(.NUMW(GW), .DENW(EW), .OUTW(GRAD_W)) u_gx (
      .clk (clk), .en (en), .num (gx_num[k]), .den (area_f), .quot (gx[k])
    );
    lts_divider #(.NUMW(GW), .DENW(EW), .OUTW(GRAD_W)) u_gy (
      .clk (clk), .en (en), .num (gy_num[k]), .den (area_f), .quot (gy[k])
    );
  end

  // delay line for the fields that bypass the dividers
  logic [AREA_W-1:0] area_d [DIV_LAT];
  logic              degen_d [DIV_LAT];
  logic [CENT_W-1:0] cx_d [DIV_LAT];
  logic [CENT_W-1:0] cy_d [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      area_d[0]  <= AREA_W'(area_f);
      degen_d[0] <= degen_f;
      cx_d[0]    <= cx_f;
      cy_d[0]    <= cy_f;
      for (int i = 1; i < DIV_LAT; i++) begin
        area_d[i]  <= area_d[i-1];
        degen_d[i] <= degen_d[i-1];
        cx_d[i]    <= cx_d[i-1];
        cy_d[i]    <= cy_d[i-1];
      end
    end
  end

  // pack the result; drop all quotients of a degenerate triangle
  logic [M_TDATA_W-1:0] res;
  logic                 res_degen;

  always_comb begin
    res_degen = degen_d[DIV_LAT-1];
    res = '0;
    res[OFS_AREA +: AREA_W] = area_d[DIV_LAT-1];
    res[OFS_CX +: CENT_W]   = cx_d[DIV_LAT-1];
    res[OFS_CY +: CENT_W]   = cy_d[DIV_LAT-1];
    if (!res_degen) begin
      res[OFS_S0 +: SHAPE_W]    = shape[0];
      res[OFS_S1 +: SHAPE_W]    = shape[1];
      res[OFS_S2 +: SHAPE_W]    = shape[2];
      res[OFS_G0X +: GRAD_W]    = gx[0];
      res[OFS_G0Y +: GRAD_W]    = gy[0];
      res[OFS_G1X +: GRAD_W]    = gx[1];
      res[OFS_G1Y +: GRAD_W]    = gy[1];
      res[OFS_G2 +: 2*GRAD_W]   = {gx[2], gy[2]};
    end
  end

  logic                 vld_last;
  logic [M_TDATA_W-1:0] skid_data;
  logic                 skid_user;
  logic                 load_out, load_skid, drain_skid;

  always_comb begin
    vld_last   = vld[LAT-1];
    drain_skid = skid_valid && m_tready;
    load_out   = en && vld_last && (!m_tvalid || m_tready);
    load_skid  = en && vld_last && m_tvalid && !m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (en) vld <= {vld[LAT-2:0], s_tvalid};
      if (drain_skid) skid_valid <= 1'b0;
      else if (load_skid) skid_valid <= 1'b1;
      if (load_out || drain_skid) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_skid) begin
      m_tdata <= skid_data;
      m_tuser <= skid_user;
    end else if (load_out) begin
      m_tdata <= res;
      m_tuser <= res_degen;
    end
    if (load_skid) begin
      skid_data <= res;
      skid_user <= res_degen;
    end
  end

endmodule

>>> src/lts_checker.sv
// ----------------------------------------------------------------------------
// lts_checker: port-level checks of the triangle shape function block
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lts_checker import lts_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("result pending after reset");

  // the input side only stalls behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // a degenerate triangle has zero shape values and gradients
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[USED_W-1:OFS_S0] == '0)
    else $error("degenerate result with nonzero quotients");

endmodule

bind linear_triangle_shape_functions lts_checker u_lts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for linear_triangle_shape_functions
// Random and directed triangles with query points go into the stream input.
// A predictor in the bench computes twice-area, degeneracy, centroid, shape
// values and gradients for each one, and the results are compared in order.
// The run is split into phases with different tolerances and idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import lts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SHAPE_LIM  = 1048575;
  localparam longint GRAD_LIM   = 8388607;
  localparam int     WATCHDOG   = 20000;
  localparam int     DRAIN_CYC  = 40;
  localparam int     NUM_PHASES = 4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] qy, qx, v2y, v2x, v1y, v1x, v0y, v0x;
  } tri_query_t;

  typedef struct {
    logic [M_TDATA_W-1:0] data;
    logic                 degen;
  } shape_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_we = 1'b0;
  logic [TOL_W-1:0]     cfg_wdata = '0;

  tri_query_t    pending_tris[$];
  shape_result_t expected_results[$];
  logic [TOL_W-1:0] tol_model = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int degen_seen = 0;
  int idle_cycles = 0;

  linear_triangle_shape_functions dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // trunc(num * 2^16 / den) clamped to [-(lim+1), lim]; den is never zero here
  function automatic longint quot_sat(longint num, longint den, longint lim);
    logic neg;
    longint un, ud, q;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = un / ud;
    if (q > ((lim + 1) >>> 16)) return neg ? -(lim + 1) : lim;
    q = (un * 65536) / ud;
    if (neg) return q > lim + 1 ? -(lim + 1) : -q;
    return q > lim ? lim : q;
  endfunction

  function automatic shape_result_t predict_shapes(tri_query_t t);
    shape_result_t r;
    longint vx[3], vy[3], px, py, d, mag, e, sh[3], gx[3], gy[3];
    int l, m;
    vx[0] = t.v0x; vy[0] = t.v0y; vx[1] = t.v1x; vy[1] = t.v1y;
    vx[2] = t.v2x; vy[2] = t.v2y; px = t.qx; py = t.qy;
    d = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vx[2] - vx[0]) * (vy[1] - vy[0]);
    mag = d < 0 ? -d : d;
    r.degen = mag <= longint'(tol_model);
    for (int k = 0; k < 3; k++) begin
      sh[k] = 0; gx[k] = 0; gy[k] = 0;
      if (!r.degen) begin
        l = (k + 1) % 3;
        m = (k + 2) % 3;
        e = (vx[l] - px) * (vy[m] - py) - (vx[m] - px) * (vy[l] - py);
        sh[k] = quot_sat(e, d, SHAPE_LIM);
        gx[k] = quot_sat((vy[l] - vy[m]) * 256, d, GRAD_LIM);
        gy[k] = quot_sat((vx[m] - vx[l]) * 256, d, GRAD_LIM);
      end
    end
    r.data = '0;
    r.data[OFS_AREA +: AREA_W] = d[AREA_W-1:0];
    r.data[OFS_CX +: CENT_W] = 16'((vx[0] + vx[1] + vx[2]) / 3);
    r.data[OFS_CY +: CENT_W] = 16'((vy[0] + vy[1] + vy[2]) / 3);
    r.data[OFS_S0 +: SHAPE_W] = sh[0][SHAPE_W-1:0];
    r.data[OFS_S1 +: SHAPE_W] = sh[1][SHAPE_W-1:0];
    r.data[OFS_S2 +: SHAPE_W] = sh[2][SHAPE_W-1:0];
    r.data[OFS_G0X +: GRAD_W] = gx[0][GRAD_W-1:0];
    r.data[OFS_G0Y +: GRAD_W] = gy[0][GRAD_W-1:0];
    r.data[OFS_G1X +: GRAD_W] = gx[1][GRAD_W-1:0];
    r.data[OFS_G1Y +: GRAD_W] = gy[1][GRAD_W-1:0];
    r.data[OFS_G2 + GRAD_W +: GRAD_W] = gx[2][GRAD_W-1:0];
    r.data[OFS_G2 +: GRAD_W] = gy[2][GRAD_W-1:0];
    return r;
  endfunction

  // Coordinates: mostly small triangles so shape values stay in range,
  // some full-range values to reach saturation and area extremes.
  function automatic logic signed [FIELD_W-1:0] rand_coord(int span);
    case ($urandom_range(9))
      0: return FIELD_W'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(2 * span)) - span);
    endcase
  endfunction

  function automatic tri_query_t rand_tri();
    tri_query_t t;
    int span;
    span = $urandom_range(3) == 0 ? 32767 : (1 << $urandom_range(4, 12));
    t.v0x = rand_coord(span); t.v0y = rand_coord(span);
    t.v1x = rand_coord(span); t.v1y = rand_coord(span);
    t.v2x = rand_coord(span); t.v2y = rand_coord(span);
    // collinear triangle now and then
    if ($urandom_range(9) == 0) begin
      t.v2x = t.v1x + (t.v1x - t.v0x);
      t.v2y = t.v1y + (t.v1y - t.v0y);
    end
    t.qx = rand_coord(span); t.qy = rand_coord(span);
    return t;
  endfunction

  function automatic tri_query_t make_tri(int ax, int ay, int bx, int by,
                                          int cx, int cy, int px, int py);
    tri_query_t t;
    t.v0x = FIELD_W'(ax); t.v0y = FIELD_W'(ay);
    t.v1x = FIELD_W'(bx); t.v1y = FIELD_W'(by);
    t.v2x = FIELD_W'(cx); t.v2y = FIELD_W'(cy);
    t.qx = FIELD_W'(px); t.qy = FIELD_W'(py);
    return t;
  endfunction

  // Driver: advance to the next queued triangle once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_tris.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Record the expectation on the accepting edge, using the settled tolerance.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      expected_results.push_back(predict_shapes(tri_query_t'(s_tdata)));
  end

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    shape_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (m_tuser) degen_seen <= degen_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result data=%h", m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (want.data !== m_tdata || want.degen !== m_tuser) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result %0d: expected degen=%b data=%h, got degen=%b data=%h",
                     results_seen, want.degen, want.data, m_tuser, m_tdata);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (pending_tris.size() > 0 || expected_results.size() > 0 || s_tvalid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic load_tolerance(logic [TOL_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    tol_model <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_tris.size() == 0 && !s_tvalid && expected_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    logic [TOL_W-1:0] tols[NUM_PHASES];
    int idle_pct[NUM_PHASES];
    int stall_pct[NUM_PHASES];
    tols = '{0, 33'h1_ffff_ffff, 33'd65536, 33'd1 << $urandom_range(10, 30)};
    idle_pct = '{0, 65, 0, 16};
    stall_pct = '{0, 0, 65, 16};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: unit triangles both windings, vertices, outside point,
    // collinear and coincident points, full-scale extremes, saturation
    load_tolerance('0);
    pending_tris.push_back(make_tri(0, 0, 256, 0, 0, 256, 85, 85));
    pending_tris.push_back(make_tri(0, 0, 0, 256, 256, 0, 85, 85));
    pending_tris.push_back(make_tri(0, 0, 256, 0, 0, 256, 256, 0));
    pending_tris.push_back(make_tri(0, 0, 256, 0, 0, 256, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 256, 0, 0, 256, -32768, 32767));
    pending_tris.push_back(make_tri(0, 0, 256, 256, 512, 512, 1, 2));
    pending_tris.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5));
    pending_tris.push_back(make_tri(-32768, -32768, 32767, -32768, -32768,
                                    32767, 0, 0));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767,
                                    -32768, 32767, 32767));
    pending_tris.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                                    -32768, -32768));
    pending_tris.push_back(make_tri(0, 0, 1, 0, 0, 1, 32767, -32768));
    pending_tris.push_back(make_tri(0, 0, 1, 0, 0, 1, -1, -1));
    pending_tris.push_back(make_tri(-1, -1, -2, -2, -3, -1, -32768, 32767));
    pending_tris.push_back(make_tri(0, 0, 2, 1, 1, 2, 0, 0));
    pending_tris.push_back(make_tri(-32768, 0, 32767, 1, 0, -1, 0, 0));
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_tolerance(tols[p]);
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int i = 0; i < 360; i++) pending_tris.push_back(rand_tri());
      // a stretch without idling inside each phase
      wait (pending_tris.size() < 180);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait (pending_tris.size() < 120);
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      wait_drained();
    end

    $display("covered %0d results (%0d degenerate) over %0d tolerance settings",
             results_seen, degen_seen, NUM_PHASES + 1);
    $display("idle patterns: none, sender gaps, receiver stalls, both");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> linear_triangle_shape_functions.f
src/lts_pkg.sv
src/lts_front.sv
src/lts_div_cell.sv
src/lts_divider.sv
src/linear_triangle_shape_functions.sv
src/lts_checker.sv
verif/tb.sv
